// ===== rtl/gpiobl_pkg.sv =====
package gpiobl_pkg;

    localparam int PINS_PER_BANK = 16;
    localparam int DEFAULT_NUM_BANKS = 7;
    localparam int MAX_BANKS = 8;
    localparam int BANK_IDX_W = 3;
    localparam int SEL_W = 3;
    localparam int STEP_W = 3;
    localparam int WORD_W = 32;
    localparam int NIBBLES = 8;
    localparam int KEY_POS = 16;

    localparam logic [WORD_W-1:0] MODE_RESET = 32'h4444_4444;

    localparam logic ACT_READ = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BAD_BANK = 1'b1;

    localparam logic [SEL_W-1:0] REG_MODE_LOW = 3'd0;
    localparam logic [SEL_W-1:0] REG_MODE_HIGH = 3'd1;
    localparam logic [SEL_W-1:0] REG_INPUT = 3'd2;
    localparam logic [SEL_W-1:0] REG_OUTPUT = 3'd3;
    localparam logic [SEL_W-1:0] REG_SET_RESET = 3'd4;
    localparam logic [SEL_W-1:0] REG_LOCK = 3'd5;

    localparam logic [STEP_W-1:0] STEP_NONE = 3'd0;
    localparam logic [STEP_W-1:0] STEP_KEY1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_KEY0 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_KEY1_AGAIN = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LOCKED = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] mode_low;
        logic [WORD_W-1:0] mode_high;
        logic [PINS_PER_BANK-1:0] out_latch;
        logic [PINS_PER_BANK-1:0] lock_mask;
        logic [STEP_W-1:0] lock_step;
    } bank_entry_t;

    localparam bank_entry_t ENTRY_RESET = '{
        mode_low: MODE_RESET,
        mode_high: MODE_RESET,
        out_latch: '0,
        lock_mask: '0,
        lock_step: STEP_NONE
    };

    typedef struct packed {
        logic action;
        logic [BANK_IDX_W-1:0] bank_index;
        logic bank_ok;
        logic [SEL_W-1:0] reg_select;
        logic [WORD_W-1:0] write_data;
        logic [PINS_PER_BANK-1:0] pin_levels;
    } access_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic status;
        logic [PINS_PER_BANK-1:0] out_levels;
        logic [WORD_W-1:0] mode_low_word;
        logic [WORD_W-1:0] mode_high_word;
        logic bank_locked;
    } result_t;

    // Expands eight pin bits of the lock mask into a nibble mask of one mode word.
    function automatic logic [WORD_W-1:0] frozen_nibbles(
        input logic [NIBBLES-1:0] pins
    );
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < NIBBLES; i++)
        begin
            m[4*i +: 4] = {4{pins[i]}};
        end
        return m;
    endfunction

endpackage

// ===== rtl/gpiobl_req_if.sv =====
interface gpiobl_req_if;
    import gpiobl_pkg::*;

    logic valid;
    logic ready;
    logic action;
    logic [BANK_IDX_W-1:0] bank_index;
    logic [SEL_W-1:0] reg_select;
    logic [WORD_W-1:0] write_data;
    logic [PINS_PER_BANK-1:0] pin_levels;

    modport source (
        output valid, action, bank_index, reg_select, write_data, pin_levels,
        input ready
    );

    modport sink (
        input valid, action, bank_index, reg_select, write_data, pin_levels,
        output ready
    );
endinterface

// ===== rtl/gpiobl_rsp_if.sv =====
interface gpiobl_rsp_if;
    import gpiobl_pkg::*;

    logic valid;
    logic ready;
    logic [WORD_W-1:0] read_data;
    logic status;
    logic [PINS_PER_BANK-1:0] out_levels;
    logic [WORD_W-1:0] mode_low_word;
    logic [WORD_W-1:0] mode_high_word;
    logic bank_locked;

    modport source (
        output valid, read_data, status, out_levels, mode_low_word, mode_high_word,
        bank_locked,
        input ready
    );

    modport sink (
        input valid, read_data, status, out_levels, mode_low_word, mode_high_word,
        bank_locked,
        output ready
    );
endinterface

// ===== rtl/gpiobl_mem.sv =====
module gpiobl_mem
    import gpiobl_pkg::*;
#(
    parameter int NUM_BANKS = DEFAULT_NUM_BANKS,
    parameter int ADDR_W = 3
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output bank_entry_t rd_data,
    input  logic wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  bank_entry_t wr_data
);

    bank_entry_t mem [NUM_BANKS];
    logic [NUM_BANKS-1:0] written_reg;
    bank_entry_t rdata_reg;
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as the reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvalid_reg <= written_reg[rd_addr];
            end
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : ENTRY_RESET;

endmodule

// ===== rtl/gpiobl_update.sv =====
module gpiobl_update
    import gpiobl_pkg::*;
(
    input  access_t acc,
    input  bank_entry_t cur,
    output bank_entry_t nxt,
    output result_t res
);

    logic locked;
    logic [WORD_W-1:0] fz_low;
    logic [WORD_W-1:0] fz_high;
    logic [PINS_PER_BANK-1:0] new_mask;
    logic [PINS_PER_BANK-1:0] pin_set;
    logic [PINS_PER_BANK-1:0] pin_clear;
    logic key;
    logic same_mask;
    logic [WORD_W-1:0] rd;

    always_comb
    begin
        locked = (cur.lock_step == STEP_LOCKED);
        fz_low = locked ? frozen_nibbles(cur.lock_mask[NIBBLES-1:0]) : '0;
        fz_high = locked ? frozen_nibbles(cur.lock_mask[PINS_PER_BANK-1:NIBBLES]) : '0;
        new_mask = acc.write_data[PINS_PER_BANK-1:0];
        pin_set = acc.write_data[PINS_PER_BANK-1:0];
        pin_clear = acc.write_data[WORD_W-1:PINS_PER_BANK];
        key = acc.write_data[KEY_POS];
        same_mask = (new_mask == cur.lock_mask);

        nxt = cur;
        rd = '0;
        if (acc.action == ACT_WRITE)
        begin
            unique case (acc.reg_select)
                REG_MODE_LOW:
                    nxt.mode_low = (acc.write_data & ~fz_low) | (cur.mode_low & fz_low);
                REG_MODE_HIGH:
                    nxt.mode_high = (acc.write_data & ~fz_high) | (cur.mode_high & fz_high);
                REG_OUTPUT:
                    nxt.out_latch = acc.write_data[PINS_PER_BANK-1:0];
                REG_SET_RESET:
                    nxt.out_latch = (cur.out_latch & ~pin_clear) | pin_set;
                REG_LOCK:
                begin
                    if (!locked)
                    begin
                        nxt.lock_mask = new_mask;
                        if (cur.lock_step == STEP_KEY1 && !key && same_mask)
                        begin
                            nxt.lock_step = STEP_KEY0;
                        end
                        else if (cur.lock_step == STEP_KEY0 && key && same_mask)
                        begin
                            nxt.lock_step = STEP_KEY1_AGAIN;
                        end
                        else
                        begin
                            nxt.lock_step = key ? STEP_KEY1 : STEP_NONE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (acc.reg_select)
                REG_MODE_LOW:
                    rd = cur.mode_low;
                REG_MODE_HIGH:
                    rd = cur.mode_high;
                REG_INPUT:
                    rd = {{(WORD_W-PINS_PER_BANK){1'b0}}, acc.pin_levels};
                REG_OUTPUT:
                    rd = {{(WORD_W-PINS_PER_BANK){1'b0}}, cur.out_latch};
                REG_LOCK:
                begin
                    rd = {{(WORD_W-PINS_PER_BANK-1){1'b0}}, locked, cur.lock_mask};
                    // The first read of the lock register after the full key sequence completes the lock.
                    if (cur.lock_step == STEP_KEY1_AGAIN)
                    begin
                        nxt.lock_step = STEP_LOCKED;
                    end
                end
                default:
                    rd = '0;
            endcase
        end

        if (acc.bank_ok)
        begin
            res.read_data = rd;
            res.status = STATUS_OK;
            res.out_levels = nxt.out_latch;
            res.mode_low_word = nxt.mode_low;
            res.mode_high_word = nxt.mode_high;
            res.bank_locked = (nxt.lock_step == STEP_LOCKED);
        end
        else
        begin
            res = '0;
            res.status = STATUS_BAD_BANK;
        end
    end

endmodule

// ===== rtl/gpio_bank_with_bit_set_and_lock.sv =====
// An accepted request is registered in stage 1 while its bank state is read, then its
// result goes to the output register. One request per cycle unless rsp.ready stalls;
// bank state is written back as the request advances, with forwarding for the same bank.
// Reset (rst_n, asynchronous, active low) empties the pipeline and marks every bank
// unwritten, so each bank reads as its reset value until its first write-back.
module gpio_bank_with_bit_set_and_lock
    import gpiobl_pkg::*;
#(
    parameter int NUM_BANKS = DEFAULT_NUM_BANKS
)
(
    input  logic clk,
    input  logic rst_n,
    gpiobl_req_if.sink req,
    gpiobl_rsp_if.source rsp
);

    localparam int ADDR_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    logic accept;
    logic advance;
    logic in_bank_ok;
    access_t in_acc;

    logic s1_valid_reg;
    logic s1_valid_next;
    access_t s1_acc_reg;
    logic fwd_hit_reg;
    logic fwd_hit_next;
    bank_entry_t fwd_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    result_t out_reg;

    bank_entry_t mem_rd;
    bank_entry_t cur_entry;
    bank_entry_t upd_entry;
    result_t upd_res;

    assign in_bank_ok = (32'(req.bank_index) < NUM_BANKS);
    assign in_acc = '{
        action: req.action,
        bank_index: req.bank_index,
        bank_ok: in_bank_ok,
        reg_select: req.reg_select,
        write_data: req.write_data,
        pin_levels: req.pin_levels
    };

    assign advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept = req.valid && req.ready;

    gpiobl_mem #(
        .NUM_BANKS(NUM_BANKS),
        .ADDR_W(ADDR_W)
    ) u_mem (
        .clk(clk),
        .rst_n(rst_n),
        .rd_en(accept && in_bank_ok),
        .rd_addr(req.bank_index[ADDR_W-1:0]),
        .rd_data(mem_rd),
        .wr_en(advance && s1_acc_reg.bank_ok),
        .wr_addr(s1_acc_reg.bank_index[ADDR_W-1:0]),
        .wr_data(upd_entry)
    );

    // The memory still holds the old entry when the request just ahead wrote
    // the same bank in the cycle this one was accepted.
    assign cur_entry = fwd_hit_reg ? fwd_data_reg : mem_rd;

    gpiobl_update u_update (
        .acc(s1_acc_reg),
        .cur(cur_entry),
        .nxt(upd_entry),
        .res(upd_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        fwd_hit_next = fwd_hit_reg;
        if (accept)
        begin
            fwd_hit_next = advance && s1_acc_reg.bank_ok && in_bank_ok
                && (s1_acc_reg.bank_index == req.bank_index);
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            fwd_hit_reg <= fwd_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_acc_reg <= in_acc;
            fwd_data_reg <= upd_entry;
        end
        if (advance)
        begin
            out_reg <= upd_res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = out_reg.read_data;
    assign rsp.status = out_reg.status;
    assign rsp.out_levels = out_reg.out_levels;
    assign rsp.mode_low_word = out_reg.mode_low_word;
    assign rsp.mode_high_word = out_reg.mode_high_word;
    assign rsp.bank_locked = out_reg.bank_locked;

endmodule
